[rtl/bekc_pkg.sv]
// ----------------------------------------------------------------------------
// bekc_pkg: shared types and constants of the end knot change unit
// Request payloads, datapath commands and controller states.
// ----------------------------------------------------------------------------
package bekc_pkg;

  // Request actions
  typedef enum logic [1:0] {
    ACT_OLD_KNOT = 2'd0,
    ACT_NEW_KNOT = 2'd1,
    ACT_COORD    = 2'd2,
    ACT_RUN      = 2'd3
  } action_e;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEGREE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COORDS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_END    = 2'd2;

  // Index widths sized for the largest supported window
  localparam int IDX_W = 5;
  localparam int PT_W  = 4;
  localparam int CRD_W = 3;

  // Divider: 49-bit dividend, one quotient bit per cycle
  localparam int DIV_STEPS = 49;
  localparam int DIVC_W    = 6;
  localparam logic [30:0] ALPHA_MAX = 31'h7fff_ffff;

  typedef struct packed {
    action_e            action;
    logic [3:0]         slot;
    logic [1:0]         coord;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         point;
    logic [1:0]         coord_out;
    logic signed [31:0] result_value;
    logic               last;
    logic               fault;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_START,
    DP_RD_DEN,
    DP_CHK,
    DP_COPY_RD,
    DP_COPY_WR,
    DP_RD_T,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_MUL,
    DP_BLEND,
    DP_EMIT_RD,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e             op;
    logic [IDX_W-1:0]   old_a;
    logic [IDX_W-1:0]   old_b;
    logic [PT_W-1:0]    new_a;
    logic               t_new;
    logic [PT_W-1:0]    pt_a;
    logic [PT_W-1:0]    pt_b;
    logic [CRD_W-1:0]   crd;
    logic [2:0]         point;
    logic [1:0]         coord;
    logic               last;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_BL_RD1,
    ST_BL_RD2,
    ST_BL_INIT,
    ST_BL_DIV,
    ST_BL_MUL,
    ST_BL_WR,
    ST_EM_RD,
    ST_EM_OUT
  } ctrl_state_e;

endpackage

[rtl/bspline_end_knot_change_unit.sv]
// ----------------------------------------------------------------------------
// bspline_end_knot_change_unit: Oslo end knot change for one B-spline curve
// Load requests (old knot, new knot, control coordinate) write the stores.
// A run request first checks all n(n+1)/2 knot divisors, then for every new
// point and coordinate copies the n+1 source values, evaluates the n(n+1)/2
// blends of the triangle and emits one result. Each blend runs the bit-serial
// ratio divider; a zero divisor skips the divider steps and raises fault on
// every result of the run. Loads are accepted only between runs; the last
// result may still wait in the output register while new loads go in.
// ----------------------------------------------------------------------------
module bspline_end_knot_change_unit #(
  parameter int MAX_DEGREE = 7,
  parameter int MAX_COORDS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bekc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bekc_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bekc_pkg::out_item_t             out_item_o
);

  bekc_pkg::dp_cmd_t  cmd;
  bekc_pkg::dp_stat_t stat;

  // Configuration writes always complete
  assign cfg_ready_o = 1'b1;

  bekc_ctrl #(
    .MAX_DEGREE (MAX_DEGREE),
    .MAX_COORDS (MAX_COORDS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_item_i.action),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  bekc_dp #(
    .MAX_DEGREE (MAX_DEGREE),
    .MAX_COORDS (MAX_COORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .stat_o      (stat)
  );

  // A result that is not the last one means the run is still in progress
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> !in_ready_o)
    else $error("request accepted in the middle of a run");

  // All results of one run carry the same fault flag
  a_fault_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.last |=>
      !out_valid_o || (out_item_o.fault == $past(out_item_o.fault)))
    else $error("fault flag changed within a run");

  // Coordinate index stays within the configured store
  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(out_item_o.coord_out) < MAX_COORDS)
    else $error("result coordinate out of range");

endmodule

[rtl/bekc_dp.sv]
// ----------------------------------------------------------------------------
// bekc_dp: knot and point stores, ratio divider, blend unit, result register
// Executes one command from the controller per cycle.
// ----------------------------------------------------------------------------
module bekc_dp #(
  parameter int MAX_DEGREE = 7,
  parameter int MAX_COORDS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bekc_pkg::dp_cmd_t   cmd_i,
  input  bekc_pkg::in_item_t  in_item_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output bekc_pkg::out_item_t out_item_o,
  output bekc_pkg::dp_stat_t  stat_o
);

  localparam int OLD_DEPTH = 2 * MAX_DEGREE + 1;
  localparam int NEW_DEPTH = MAX_DEGREE + 1;
  localparam int OW = $clog2(OLD_DEPTH);
  localparam int NW = $clog2(NEW_DEPTH);
  localparam int CW = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
  localparam int DIVC_W = bekc_pkg::DIVC_W;

  // Stores
  logic signed [31:0] old_mem  [OLD_DEPTH];
  logic signed [31:0] new_mem  [NEW_DEPTH];
  logic signed [31:0] src_mem  [NEW_DEPTH][MAX_COORDS];
  logic signed [31:0] work_mem [NEW_DEPTH];

  // Registered read data
  logic signed [31:0] knot_i_q, knot_d_q, t_old_q, t_new_q;
  logic signed [31:0] wa_q, wb_q, src_q;

  // Divider and blend state
  logic [32:0]        dm_q, rem_q;
  logic [48:0]        quo_q;
  logic               neg_q, zero_q, pneg_q;
  logic [DIVC_W-1:0]  dcnt_q;
  logic [63:0]        prod_q;

  logic               fault_q, out_valid_q;
  bekc_pkg::out_item_t out_q;

  logic [OW-1:0] oa, ob;
  logic [NW-1:0] na, pa, pb;
  logic [CW-1:0] ca;

  assign oa = cmd_i.old_a[OW-1:0];
  assign ob = cmd_i.old_b[OW-1:0];
  assign na = cmd_i.new_a[NW-1:0];
  assign pa = cmd_i.pt_a[NW-1:0];
  assign pb = cmd_i.pt_b[NW-1:0];
  assign ca = cmd_i.crd[CW-1:0];

  // Ratio setup: exact differences and their magnitudes
  logic signed [31:0] t_val;
  logic signed [32:0] num, den;
  logic [32:0]        nm, dmag_den;
  logic [48:0]        dividend;

  always_comb begin
    t_val    = cmd_i.t_new ? t_new_q : t_old_q;
    num      = {t_val[31], t_val} - {knot_i_q[31], knot_i_q};
    den      = {knot_d_q[31], knot_d_q} - {knot_i_q[31], knot_i_q};
    nm       = num[32] ? 33'(-num) : 33'(num);
    dmag_den = den[32] ? 33'(-den) : 33'(den);
    dividend = {nm[32:0], 16'h0000} + 49'(dmag_den >> 1);
  end

  // Restoring divider step
  logic [33:0] trial;
  logic        ge;
  logic [32:0] rem_d;

  always_comb begin
    trial = {rem_q, quo_q[48]};
    ge    = trial >= {1'b0, dm_q};
    rem_d = ge ? 33'(trial - {1'b0, dm_q}) : trial[32:0];
  end

  // Saturated ratio magnitude
  logic [30:0] amag;
  assign amag = zero_q ? 31'd0 : ((|quo_q[48:31]) ? bekc_pkg::ALPHA_MAX : quo_q[30:0]);

  // Blend: a + alpha*(b-a), rounded and saturated
  logic signed [32:0] diff;
  logic [32:0]        dmag;
  logic [48:0]        qv;
  logic signed [49:0] aext, sum;
  logic signed [31:0] blend_res;

  always_comb begin
    diff = {wb_q[31], wb_q} - {wa_q[31], wa_q};
    dmag = diff[32] ? 33'(-diff) : 33'(diff);
    qv   = {1'b0, prod_q[63:16]} + 49'(prod_q[15]);
    aext = 50'(wa_q);
    sum  = pneg_q ? (aext - $signed({1'b0, qv})) : (aext + $signed({1'b0, qv}));
    if (sum > 50'sd2147483647) begin
      blend_res = 32'sh7fff_ffff;
    end else if (sum < -50'sd2147483648) begin
      blend_res = 32'sh8000_0000;
    end else begin
      blend_res = sum[31:0];
    end
  end

  // Store writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == bekc_pkg::DP_LOAD) begin
      unique case (in_item_i.action)
        bekc_pkg::ACT_OLD_KNOT: begin
          if (int'(in_item_i.slot) < OLD_DEPTH) old_mem[OW'(in_item_i.slot)] <= in_item_i.value;
        end
        bekc_pkg::ACT_NEW_KNOT: begin
          if (int'(in_item_i.slot) < NEW_DEPTH) new_mem[NW'(in_item_i.slot)] <= in_item_i.value;
        end
        bekc_pkg::ACT_COORD: begin
          if (int'(in_item_i.slot) <= MAX_DEGREE && int'(in_item_i.coord) < MAX_COORDS) begin
            src_mem[NW'(in_item_i.slot)][CW'(in_item_i.coord)] <= in_item_i.value;
          end
        end
        bekc_pkg::ACT_RUN: begin
        end
      endcase
    end
    if (cmd_i.op == bekc_pkg::DP_COPY_WR) work_mem[pa] <= src_q;
    if (cmd_i.op == bekc_pkg::DP_BLEND)   work_mem[pb] <= blend_res;
  end

  // Store reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == bekc_pkg::DP_RD_DEN) begin
      knot_i_q <= old_mem[oa];
      knot_d_q <= old_mem[ob];
    end
    if (cmd_i.op == bekc_pkg::DP_RD_T) begin
      t_old_q <= old_mem[oa];
      t_new_q <= new_mem[na];
      wa_q    <= work_mem[pa];
      wb_q    <= work_mem[pb];
    end
    if (cmd_i.op == bekc_pkg::DP_EMIT_RD) wa_q <= work_mem[pa];
    if (cmd_i.op == bekc_pkg::DP_COPY_RD) src_q <= src_mem[pa][ca];
  end

  // Divider and multiplier
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == bekc_pkg::DP_DIV_INIT) begin
      dm_q   <= dmag_den;
      rem_q  <= '0;
      quo_q  <= dividend;
      neg_q  <= num[32] ^ den[32];
      zero_q <= (den == '0);
      dcnt_q <= '0;
    end else if (cmd_i.op == bekc_pkg::DP_DIV_STEP) begin
      rem_q  <= rem_d;
      quo_q  <= {quo_q[47:0], ge};
      dcnt_q <= dcnt_q + DIVC_W'(1);
    end
    if (cmd_i.op == bekc_pkg::DP_MUL) begin
      prod_q <= 64'(amag) * 64'(dmag);
      pneg_q <= neg_q ^ diff[32];
    end
  end

  // Fault flag and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == bekc_pkg::DP_START) fault_q <= 1'b0;
      else if (cmd_i.op == bekc_pkg::DP_CHK && knot_i_q == knot_d_q) fault_q <= 1'b1;
      if (cmd_i.op == bekc_pkg::DP_EMIT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == bekc_pkg::DP_EMIT) begin
      out_q.point        <= cmd_i.point;
      out_q.coord_out    <= cmd_i.coord;
      out_q.result_value <= wa_q;
      out_q.last         <= cmd_i.last;
      out_q.fault        <= fault_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;
  assign stat_o.div_done = zero_q || (dcnt_q == DIVC_W'(bekc_pkg::DIV_STEPS));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

[rtl/bekc_ctrl.sv]
// ----------------------------------------------------------------------------
// bekc_ctrl: configuration registers and run sequencer
// Walks the divisor check, the point copy, the blend triangle and the emits.
// ----------------------------------------------------------------------------
module bekc_ctrl #(
  parameter int MAX_DEGREE = 7,
  parameter int MAX_COORDS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [bekc_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [31:0]                         cfg_data_i,
  input  logic                                in_valid_i,
  input  bekc_pkg::action_e                   in_action_i,
  output logic                                in_ready_o,
  output bekc_pkg::dp_cmd_t                   cmd_o,
  input  bekc_pkg::dp_stat_t                  stat_i
);

  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int CW = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;

  logic [2:0] degree_q, coord_count_q;
  logic       end_sel_q;

  bekc_pkg::ctrl_state_e state_q, state_d;
  logic [DW-1:0] k_q, k_d, j_q, j_d, i_q, i_d;
  logic [CW-1:0] c_q, c_d;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q      <= 3'd3;
      coord_count_q <= 3'd3;
      end_sel_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        bekc_pkg::CFG_DEGREE: degree_q      <= cfg_data_i[2:0];
        bekc_pkg::CFG_COORDS: coord_count_q <= cfg_data_i[2:0];
        bekc_pkg::CFG_END:    end_sel_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Loop bounds and window indexes
  logic [DW-1:0] n, jlo, ihi;
  logic [CW-1:0] c_last;
  logic          run_ok, pair_end, j_end, last;
  logic [bekc_pkg::IDX_W-1:0] dx, t_old;
  logic [bekc_pkg::PT_W-1:0]  t_newi, pt_lo;
  logic          t_new;

  always_comb begin
    int m;
    int nn;
    int ncc;
    nn       = (int'(degree_q) > MAX_DEGREE) ? MAX_DEGREE : int'(degree_q);
    ncc      = (int'(coord_count_q) > MAX_COORDS) ? MAX_COORDS : int'(coord_count_q);
    n        = DW'(nn);
    c_last   = CW'(ncc - 1);
    run_ok   = (degree_q != 3'd0) && (coord_count_q != 3'd0);
    jlo      = end_sel_q ? DW'(0) : DW'(1);
    ihi      = end_sel_q ? DW'(nn - 1) : DW'(nn);
    pair_end = (i_q == j_q);
    j_end    = (j_q == ihi);
    last     = (c_q == c_last) && (int'(k_q) == nn - 1);
    dx       = bekc_pkg::IDX_W'(int'(i_q) + int'(ihi) + 1 - int'(j_q));
    pt_lo    = bekc_pkg::PT_W'(int'(i_q) - int'(jlo));
    m        = int'(k_q) + int'(j_q);
    if (!end_sel_q) begin
      t_new  = (m <= nn);
      t_old  = bekc_pkg::IDX_W'(m);
      t_newi = bekc_pkg::PT_W'(m);
    end else begin
      t_new  = (m >= nn - 1);
      t_old  = bekc_pkg::IDX_W'(m + 1);
      t_newi = bekc_pkg::PT_W'(m - nn + 1);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bekc_pkg::ST_IDLE: begin
        if (in_valid_i && in_action_i == bekc_pkg::ACT_RUN && run_ok) state_d = bekc_pkg::ST_CHK_RD;
      end
      bekc_pkg::ST_CHK_RD:  state_d = bekc_pkg::ST_CHK_EV;
      bekc_pkg::ST_CHK_EV: begin
        if (pair_end && j_end) state_d = bekc_pkg::ST_COPY_RD;
        else state_d = bekc_pkg::ST_CHK_RD;
      end
      bekc_pkg::ST_COPY_RD: state_d = bekc_pkg::ST_COPY_WR;
      bekc_pkg::ST_COPY_WR: begin
        if (i_q == n) state_d = bekc_pkg::ST_BL_RD1;
        else state_d = bekc_pkg::ST_COPY_RD;
      end
      bekc_pkg::ST_BL_RD1:  state_d = bekc_pkg::ST_BL_RD2;
      bekc_pkg::ST_BL_RD2:  state_d = bekc_pkg::ST_BL_INIT;
      bekc_pkg::ST_BL_INIT: state_d = bekc_pkg::ST_BL_DIV;
      bekc_pkg::ST_BL_DIV: begin
        if (stat_i.div_done) state_d = bekc_pkg::ST_BL_MUL;
      end
      bekc_pkg::ST_BL_MUL:  state_d = bekc_pkg::ST_BL_WR;
      bekc_pkg::ST_BL_WR: begin
        if (pair_end && j_end) state_d = bekc_pkg::ST_EM_RD;
        else state_d = bekc_pkg::ST_BL_RD1;
      end
      bekc_pkg::ST_EM_RD:   state_d = bekc_pkg::ST_EM_OUT;
      bekc_pkg::ST_EM_OUT: begin
        if (stat_i.out_free) state_d = last ? bekc_pkg::ST_IDLE : bekc_pkg::ST_COPY_RD;
      end
      default: state_d = bekc_pkg::ST_IDLE;
    endcase
  end

  // Loop counters
  always_comb begin
    k_d = k_q;
    c_d = c_q;
    j_d = j_q;
    i_d = i_q;
    unique case (state_q)
      bekc_pkg::ST_IDLE: begin
        j_d = jlo;
        i_d = ihi;
      end
      bekc_pkg::ST_CHK_EV: begin
        if (!pair_end) begin
          i_d = i_q - DW'(1);
        end else if (!j_end) begin
          j_d = j_q + DW'(1);
          i_d = ihi;
        end else begin
          k_d = '0;
          c_d = '0;
          i_d = '0;
        end
      end
      bekc_pkg::ST_COPY_WR: begin
        if (i_q == n) begin
          j_d = jlo;
          i_d = ihi;
        end else begin
          i_d = i_q + DW'(1);
        end
      end
      bekc_pkg::ST_BL_WR: begin
        if (!pair_end) begin
          i_d = i_q - DW'(1);
        end else if (!j_end) begin
          j_d = j_q + DW'(1);
          i_d = ihi;
        end
      end
      bekc_pkg::ST_EM_OUT: begin
        if (stat_i.out_free) begin
          i_d = '0;
          if (c_q == c_last) begin
            c_d = '0;
            k_d = k_q + DW'(1);
          end else begin
            c_d = c_q + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = bekc_pkg::DP_NOP;
    cmd_o.old_a = (state_q == bekc_pkg::ST_BL_RD2) ? t_old : bekc_pkg::IDX_W'(i_q);
    cmd_o.old_b = dx;
    cmd_o.new_a = t_newi;
    cmd_o.t_new = t_new;
    cmd_o.pt_b  = pt_lo + bekc_pkg::PT_W'(1);
    cmd_o.crd   = bekc_pkg::CRD_W'(c_q);
    cmd_o.point = 3'(int'(k_q) + (end_sel_q ? 1 : 0));
    cmd_o.coord = 2'(c_q);
    cmd_o.last  = last;
    unique case (state_q)
      bekc_pkg::ST_EM_RD, bekc_pkg::ST_EM_OUT: cmd_o.pt_a = bekc_pkg::PT_W'(n);
      bekc_pkg::ST_COPY_RD, bekc_pkg::ST_COPY_WR: cmd_o.pt_a = bekc_pkg::PT_W'(i_q);
      default: cmd_o.pt_a = pt_lo;
    endcase
    in_ready_o = (state_q == bekc_pkg::ST_IDLE);
    unique case (state_q)
      bekc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i != bekc_pkg::ACT_RUN) cmd_o.op = bekc_pkg::DP_LOAD;
          else if (run_ok) cmd_o.op = bekc_pkg::DP_START;
        end
      end
      bekc_pkg::ST_CHK_RD:  cmd_o.op = bekc_pkg::DP_RD_DEN;
      bekc_pkg::ST_CHK_EV:  cmd_o.op = bekc_pkg::DP_CHK;
      bekc_pkg::ST_COPY_RD: cmd_o.op = bekc_pkg::DP_COPY_RD;
      bekc_pkg::ST_COPY_WR: cmd_o.op = bekc_pkg::DP_COPY_WR;
      bekc_pkg::ST_BL_RD1:  cmd_o.op = bekc_pkg::DP_RD_DEN;
      bekc_pkg::ST_BL_RD2:  cmd_o.op = bekc_pkg::DP_RD_T;
      bekc_pkg::ST_BL_INIT: cmd_o.op = bekc_pkg::DP_DIV_INIT;
      bekc_pkg::ST_BL_DIV:  cmd_o.op = stat_i.div_done ? bekc_pkg::DP_NOP : bekc_pkg::DP_DIV_STEP;
      bekc_pkg::ST_BL_MUL:  cmd_o.op = bekc_pkg::DP_MUL;
      bekc_pkg::ST_BL_WR:   cmd_o.op = bekc_pkg::DP_BLEND;
      bekc_pkg::ST_EM_RD:   cmd_o.op = bekc_pkg::DP_EMIT_RD;
      bekc_pkg::ST_EM_OUT:  cmd_o.op = stat_i.out_free ? bekc_pkg::DP_EMIT : bekc_pkg::DP_NOP;
      default: cmd_o.op = bekc_pkg::DP_NOP;
    endcase
  end

  // State and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bekc_pkg::ST_IDLE;
      k_q     <= '0;
      c_q     <= '0;
      j_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      c_q     <= c_d;
      j_q     <= j_d;
      i_q     <= i_d;
    end
  end

endmodule

[test/bspline_end_knot_change_unit_tb.sv]
// ----------------------------------------------------------------------------
// bspline_end_knot_change_unit_tb: self-checking bench of the end knot change unit
// Loads knot windows and control points, issues runs under several register
// settings and checks every new coordinate against an in-bench Oslo blossom
// predictor, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bspline_end_knot_change_unit_tb;

  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_CYC  = 100;
  localparam int LONG_HOLD  = 400;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [bekc_pkg::CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [31:0]                     cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  bekc_pkg::in_item_t              in_item_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  bekc_pkg::out_item_t             out_item_o;

  bspline_end_knot_change_unit u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_item_i, .out_valid_o, .out_ready_i, .out_item_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  int unsigned deg_r, crd_r, end_r;
  longint      old_k [15];
  longint      new_k [8];
  longint      src_pt [32];

  bekc_pkg::in_item_t  pend_q [$];
  bekc_pkg::out_item_t point_q [$];
  int        n_err, idle_cyc;
  bit        in_acc, out_acc, calm, hold_arm, hold_done;
  int        tx_cnt, rx_cnt;

  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Knot ratio in Q16.16, zero divisor flags a fault
  function automatic longint knot_ratio(longint num, longint den, inout bit flt);
    longint unsigned q;
    if (den == 0) begin
      flt = 1'b1;
      return 0;
    end
    q = ((mag64(num) << 16) + mag64(den) / 2) / mag64(den);
    if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // Affine blend a + alpha*(b-a), rounded and saturated
  function automatic longint blend(longint a, longint b, longint alpha);
    longint diff, r;
    longint unsigned m, q;
    diff = b - a;
    m = mag64(alpha) * mag64(diff);
    q = (m >> 16) + ((m >> 15) & 1);
    r = ((alpha < 0) != (diff < 0)) ? a - longint'(q) : a + longint'(q);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // Apply one accepted request; a run queues its new coordinates
  function automatic void predict_request(bekc_pkg::in_item_t it);
    longint    t [14];
    longint    alpha [8][8];
    longint    wp [32];
    longint    v;
    int        n, nc, k, j, i, c, tot;
    bit        flt;
    bekc_pkg::out_item_t r;
    bekc_pkg::out_item_t run_q [$];
    v = longint'(signed'(it.value));
    flt = 1'b0;
    case (it.action)
      bekc_pkg::ACT_OLD_KNOT: if (it.slot < 15) old_k[it.slot] = v;
      bekc_pkg::ACT_NEW_KNOT: if (it.slot < 8) new_k[it.slot] = v;
      bekc_pkg::ACT_COORD:    if (it.slot < 8) src_pt[it.slot * 4 + it.coord] = v;
      default: begin
        n  = (deg_r > 7) ? 7 : deg_r;
        nc = (crd_r > 4) ? 4 : crd_r;
        if (n == 0 || nc == 0) return;
        tot = n * nc;
        for (i = 0; i < 14; i++) t[i] = 0;
        if (end_r == 0) begin
          for (i = 0; i <= n; i++) t[i] = new_k[i];
          for (i = n + 1; i < 2 * n; i++) t[i] = old_k[i];
        end else begin
          for (i = 0; i + 1 < n; i++) t[i] = old_k[i + 1];
          for (i = 0; i <= n; i++) t[n - 1 + i] = new_k[i];
        end
        for (j = 0; j < 8; j++)
          for (i = 0; i < 8; i++) alpha[j][i] = 0;
        for (k = 0; k < n; k++) begin
          if (end_r == 0) begin
            for (j = 1; j <= n; j++)
              for (i = n; i >= j; i--)
                alpha[j][i] = knot_ratio(t[k + j] - old_k[i],
                                         old_k[i + n + 1 - j] - old_k[i], flt);
          end else begin
            for (j = 0; j < n; j++)
              for (i = n - 1; i >= j; i--)
                alpha[j][i] = knot_ratio(t[k + j] - old_k[i],
                                         old_k[n + i - j] - old_k[i], flt);
          end
          wp = src_pt;
          for (c = 0; c < nc; c++) begin
            if (end_r == 0) begin
              for (j = 1; j <= n; j++)
                for (i = n; i >= j; i--)
                  wp[i * 4 + c] = blend(wp[(i - 1) * 4 + c], wp[i * 4 + c], alpha[j][i]);
            end else begin
              for (j = 0; j < n; j++)
                for (i = n - 1; i >= j; i--)
                  wp[(i + 1) * 4 + c] = blend(wp[i * 4 + c], wp[(i + 1) * 4 + c],
                                              alpha[j][i]);
            end
            r.point        = (end_r == 0) ? 3'(k) : 3'(k + 1);
            r.coord_out    = 2'(c);
            r.result_value = wp[n * 4 + c][31:0];
            r.last         = 1'b0;
            r.fault        = 1'b0;
            run_q.push_back(r);
          end
        end
        foreach (run_q[q]) begin
          run_q[q].last  = (q + 1 == tot);
          run_q[q].fault = flt;
          point_q.push_back(run_q[q]);
        end
      end
    endcase
  endfunction

  // Handshake sampling, checking and watchdog
  always @(posedge clk_i) begin
    in_acc  <= in_valid_i && in_ready_o;
    out_acc <= out_valid_o && out_ready_i;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (in_valid_i && in_ready_o) predict_request(in_item_i);
    if (out_valid_o && out_ready_i) begin
      if (point_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %p", out_item_o);
      end else if (out_item_o.point !== point_q[0].point ||
                   out_item_o.coord_out !== point_q[0].coord_out ||
                   out_item_o.result_value !== point_q[0].result_value ||
                   out_item_o.last !== point_q[0].last ||
                   out_item_o.fault !== point_q[0].fault) begin
        n_err++;
        if (n_err <= 10) $display("mismatch exp %p act %p", point_q[0], out_item_o);
        void'(point_q.pop_front());
      end else begin
        void'(point_q.pop_front());
      end
    end
  end

  // Request driver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_acc)) begin
      if (tx_cnt > 0) begin
        tx_cnt = tx_cnt - 1;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() > 0) begin
        in_item_i  <= pend_q.pop_front();
        in_valid_i <= 1'b1;
        tx_cnt = calm ? 0 : $urandom_range(0, 16);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off once armed
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_arm && !hold_done && out_valid_o) begin
        hold_done = 1'b1;
        rx_cnt = LONG_HOLD;
      end else if (out_acc) begin
        rx_cnt = calm ? 0 : $urandom_range(0, 16);
      end else if (rx_cnt > 0) begin
        rx_cnt = rx_cnt - 1;
      end
      out_ready_i <= (rx_cnt == 0);
    end
  end

  function automatic bekc_pkg::in_item_t mk(bekc_pkg::action_e a, int s, int c,
                                            logic [31:0] v);
    bekc_pkg::in_item_t it;
    it.action = a;
    it.slot   = 4'(s);
    it.coord  = 2'(c);
    it.value  = v;
    return it;
  endfunction

  task automatic wait_idle();
    wait (pend_q.size() == 0 && !in_valid_i && point_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [bekc_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bekc_pkg::CFG_DEGREE: deg_r = data[2:0];
      bekc_pkg::CFG_COORDS: crd_r = data[2:0];
      bekc_pkg::CFG_END:    end_r = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Well-formed window: sorted knots (repeats give zero divisors), random points
  task automatic queue_window(int n, int nc);
    logic [31:0] kv;
    kv = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    for (int s = 0; s <= 2 * n; s++) begin
      pend_q.push_back(mk(bekc_pkg::ACT_OLD_KNOT, s, $urandom_range(0, 3), kv));
      kv += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 32'h0003_0000);
    end
    kv = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    for (int s = 0; s <= n; s++) begin
      pend_q.push_back(mk(bekc_pkg::ACT_NEW_KNOT, s, $urandom_range(0, 3), kv));
      kv += $urandom_range(1, 32'h0002_0000);
    end
    for (int s = 0; s <= n; s++)
      for (int c = 0; c < nc; c++)
        pend_q.push_back(mk(bekc_pkg::ACT_COORD, s, c, ($urandom_range(0, 5) == 0) ?
                            $urandom() : $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000));
  endtask

  task automatic queue_noise();
    pend_q.push_back(mk(bekc_pkg::action_e'($urandom_range(0, 2)), $urandom_range(0, 15),
                        $urandom_range(0, 3), $urandom()));
  endtask

  initial begin
    int n, nc;
    deg_r = 3;
    crd_r = 3;
    end_r = 0;
    foreach (old_k[i]) old_k[i] = 0;
    foreach (new_k[i]) new_k[i] = 0;
    foreach (src_pt[i]) src_pt[i] = 0;
    n_err = 0;
    idle_cyc = 0;
    tx_cnt = 0;
    rx_cnt = 0;
    calm = 1'b0;
    hold_arm = 1'b0;
    hold_done = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: degree 1, one coordinate, extreme values
    cfg_write(bekc_pkg::CFG_DEGREE, 32'd1);
    cfg_write(bekc_pkg::CFG_COORDS, 32'd1);
    pend_q.push_back(mk(bekc_pkg::ACT_OLD_KNOT, 0, 0, 32'h0000_0000));
    pend_q.push_back(mk(bekc_pkg::ACT_OLD_KNOT, 1, 0, 32'h0001_0000));
    pend_q.push_back(mk(bekc_pkg::ACT_OLD_KNOT, 2, 0, 32'h0002_0000));
    pend_q.push_back(mk(bekc_pkg::ACT_NEW_KNOT, 0, 0, 32'hffff_0000));
    pend_q.push_back(mk(bekc_pkg::ACT_NEW_KNOT, 1, 0, 32'h0000_8000));
    pend_q.push_back(mk(bekc_pkg::ACT_COORD, 0, 0, 32'h7fff_ffff));
    pend_q.push_back(mk(bekc_pkg::ACT_COORD, 1, 0, 32'h8000_0000));
    pend_q.push_back(mk(bekc_pkg::ACT_RUN, 0, 0, 32'h0));
    // out-of-range loads are dropped
    pend_q.push_back(mk(bekc_pkg::ACT_OLD_KNOT, 15, 3, 32'hffff_ffff));
    pend_q.push_back(mk(bekc_pkg::ACT_NEW_KNOT, 12, 3, 32'hffff_ffff));
    pend_q.push_back(mk(bekc_pkg::ACT_COORD, 9, 3, 32'hffff_ffff));
    pend_q.push_back(mk(bekc_pkg::ACT_RUN, 15, 3, 32'hffff_ffff));
    // zero divisor
    pend_q.push_back(mk(bekc_pkg::ACT_OLD_KNOT, 2, 0, 32'h0001_0000));
    pend_q.push_back(mk(bekc_pkg::ACT_RUN, 0, 0, 32'h0));
    wait_idle();
    cfg_write(bekc_pkg::CFG_END, 32'd1);
    pend_q.push_back(mk(bekc_pkg::ACT_OLD_KNOT, 2, 0, 32'h0003_0000));
    pend_q.push_back(mk(bekc_pkg::ACT_RUN, 0, 0, 32'h0));
    wait_idle();
    // degree zero gives nothing
    cfg_write(bekc_pkg::CFG_DEGREE, 32'd0);
    pend_q.push_back(mk(bekc_pkg::ACT_RUN, 0, 0, 32'h0));
    wait_idle();
    // coordinate count clamps to four; unused register index
    cfg_write(bekc_pkg::CFG_DEGREE, 32'hffff_fff9);
    cfg_write(bekc_pkg::CFG_COORDS, 32'd7);
    cfg_write(2'd3, 32'hffff_ffff);
    for (int c = 1; c < 4; c++) begin
      pend_q.push_back(mk(bekc_pkg::ACT_COORD, 0, c, $urandom()));
      pend_q.push_back(mk(bekc_pkg::ACT_COORD, 1, c, $urandom()));
    end
    pend_q.push_back(mk(bekc_pkg::ACT_RUN, 0, 0, 32'h0));
    wait_idle();

    // Random phases, mostly small degrees, one at the largest
    for (int ph = 0; ph < 4; ph++) begin
      n  = (ph == 3) ? 7 : $urandom_range(1, 2);
      nc = (ph == 2) ? 0 : ((ph == 3) ? 1 : $urandom_range(1, 4));
      cfg_write(bekc_pkg::CFG_DEGREE, 32'(n));
      cfg_write(bekc_pkg::CFG_COORDS, (nc == 0) ? 32'd0 : 32'(nc));
      cfg_write(bekc_pkg::CFG_END, (ph == 3) ? 32'd1 : 32'($urandom_range(0, 1)));
      calm = (ph == 1);
      queue_window(n, (nc == 0) ? 1 : nc);
      if ($urandom_range(0, 2) == 0) queue_noise();
      pend_q.push_back(mk(bekc_pkg::ACT_RUN, $urandom_range(0, 15), $urandom_range(0, 3),
                          $urandom()));
      if (ph == 1) hold_arm = 1'b1;
      for (int q = 0; q < 3; q++) queue_noise();
      if ($urandom_range(0, 1) == 0)
        pend_q.push_back(mk(bekc_pkg::ACT_RUN, 0, 0, $urandom()));
      wait_idle();
    end

    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bekc_pkg.sv
rtl/bekc_dp.sv
rtl/bekc_ctrl.sv
rtl/bspline_end_knot_change_unit.sv
test/bspline_end_knot_change_unit_tb.sv
